// ===== rtl/core/srle_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted range list package
// Shared widths, codes and types of the sorted range list with exclusion.
// ----------------------------------------------------------------------------
package srle_pkg;

	localparam int ADDR_W          = 64;
	localparam int IDX_W           = 5;
	localparam int COUNT_W         = 6;
	localparam int STAT_W          = 2;
	localparam int DEF_MAX_ENTRIES = 32;
	localparam int ENTRY_W         = 2 * ADDR_W;
	localparam int IN_DATA_W       = 136;
	localparam int OUT_DATA_W      = 136;

	localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(32);

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_APPEND  = 2'd1,
		REQ_EXCLUDE = 2'd2,
		REQ_READ    = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_BADIDX  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_SPLIT,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		ACT_COPY,
		ACT_COPY_STOP,
		ACT_DROP,
		ACT_SPLIT,
		ACT_NOSPACE,
		ACT_TRIM_END,
		ACT_TRIM_START
	} act_t;

	typedef struct packed {
		logic stop;
		logic full;
	} walk_ctl_t;

endpackage

// ===== rtl/core/srle_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srle_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/core/srle_cmp.sv =====
// ----------------------------------------------------------------------------
// Range compare unit
// Classifies one stored range against the exclusion interval.
// ----------------------------------------------------------------------------
module srle_cmp (
	input  logic [srle_pkg::ADDR_W-1:0] ms,
	input  logic [srle_pkg::ADDR_W-1:0] me,
	input  logic [srle_pkg::ADDR_W-1:0] ent_start,
	input  logic [srle_pkg::ADDR_W-1:0] ent_end,
	input  srle_pkg::walk_ctl_t         ctl,
	output srle_pkg::act_t              act
);

	import srle_pkg::*;

	logic below;
	logic beyond;
	logic cov_lo;
	logic cov_hi;

	assign below  = ms > ent_end;
	assign beyond = me < ent_start;
	assign cov_lo = ms <= ent_start;
	assign cov_hi = me >= ent_end;

	always_comb begin
		if (ctl.stop || below) begin
			act = ACT_COPY;
		end else if (beyond) begin
			act = ACT_COPY_STOP;
		end else if (cov_lo && cov_hi) begin
			act = ACT_DROP;
		end else if (!cov_lo && !cov_hi) begin
			act = ctl.full ? ACT_NOSPACE : ACT_SPLIT;
		end else if (!cov_lo) begin
			act = ACT_TRIM_END;
		end else begin
			act = ACT_TRIM_START;
		end
	end

endmodule

// ===== rtl/core/sorted_range_list_exclude_core.sv =====
// ----------------------------------------------------------------------------
// Sorted range list with exclusion
// Ordered list of disjoint inclusive ranges with clear, append, exclude, read.
// ----------------------------------------------------------------------------
// Clear and append go straight to the result; a valid read waits for RAM data.
// Exclude goes straight to the result for an inverted interval or empty list;
// else the walk reads every stored entry through the compare unit and writes each
// kept one to the other RAM bank, one entry a cycle unless a split stalls it.
// A finished result waits for a free output register, and the core stays not ready.
// Asynchronous reset empties the list and sets the capacity to 32.
// ----------------------------------------------------------------------------
module sorted_range_list_exclude_core #(
	parameter int MAX_ENTRIES = srle_pkg::DEF_MAX_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [srle_pkg::COUNT_W-1:0]     cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// range_start, range_end, entry_index, zero pad
	input  logic [srle_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status, count, entry_start, entry_end
	output logic [srle_pkg::OUT_DATA_W-1:0]  m_tdata
);

	import srle_pkg::*;

	localparam int IW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RAM_DEPTH = 2 * (1 << IW);
	localparam int AW        = IW + 1;
	localparam logic [COUNT_W:0] MAX_C = (COUNT_W + 1)'(MAX_ENTRIES);

	state_t               state_q;
	state_t               state_d;
	logic                 bank_q;
	logic [COUNT_W-1:0]   cap_q;
	logic [COUNT_W-1:0]   cap;
	logic [COUNT_W-1:0]   cnt_q;
	logic [COUNT_W-1:0]   orig_q;
	logic [COUNT_W-1:0]   ptr_q;
	logic [COUNT_W-1:0]   ptr_inc;
	logic [COUNT_W-1:0]   w_q;
	logic [COUNT_W-1:0]   rd_idx;
	logic                 stop_q;
	logic                 full;
	logic                 last;
	logic                 walk_end;
	logic                 accept;
	logic                 out_free;
	req_t                 req;
	logic [ADDR_W-1:0]    in_start;
	logic [ADDR_W-1:0]    in_end;
	logic [IDX_W-1:0]     in_idx;
	logic                 idx_ok;
	logic [ADDR_W-1:0]    ms_q;
	logic [ADDR_W-1:0]    me_q;
	logic [ADDR_W-1:0]    ms_m1_q;
	logic [ADDR_W-1:0]    me_p1_q;
	logic [ADDR_W-1:0]    spl_e_q;
	stat_t                res_status_q;
	logic [ADDR_W-1:0]    res_start_q;
	logic [ADDR_W-1:0]    res_end_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [ENTRY_W-1:0]   rd_data;
	logic [ADDR_W-1:0]    ent_s;
	logic [ADDR_W-1:0]    ent_e;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic [AW-1:0]        rd_addr;
	walk_ctl_t            ctl;
	act_t                 act;

	assign in_start = s_tdata[ADDR_W-1:0];
	assign in_end   = s_tdata[2*ADDR_W-1:ADDR_W];
	assign in_idx   = s_tdata[2*ADDR_W+IDX_W-1:2*ADDR_W];
	assign req      = req_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign cap     = ({1'b0, cap_q} > MAX_C) ? MAX_C[COUNT_W-1:0] : cap_q;
	assign full    = cnt_q >= cap;
	assign idx_ok  = {1'b0, in_idx} < cnt_q;
	assign ptr_inc = ptr_q + 1'b1;
	assign last    = ptr_inc == orig_q;
	assign ent_s   = rd_data[ADDR_W-1:0];
	assign ent_e   = rd_data[ENTRY_W-1:ADDR_W];

	assign ctl.stop = stop_q;
	assign ctl.full = full;

	assign walk_end = ((state_q == ST_WALK) && (act != ACT_SPLIT) && last) ||
		((state_q == ST_SPLIT) && (ptr_q == orig_q));

	srle_cmp u_cmp (
		.ms        (ms_q),
		.me        (me_q),
		.ent_start (ent_s),
		.ent_end   (ent_e),
		.ctl       (ctl),
		.act       (act)
	);

	srle_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (req)
						REQ_EXCLUDE: begin
							if ((in_start > in_end) || (cnt_q == '0)) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_WALK;
							end
						end
						REQ_READ: begin
							state_d = idx_ok ? ST_RDWAIT : ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (act == ACT_SPLIT) begin
					state_d = ST_SPLIT;
				end else if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_SPLIT: begin
				state_d = (ptr_q == orig_q) ? ST_DONE : ST_WALK;
			end
			ST_RDWAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_idx  = ptr_q;
		wr_en   = 1'b0;
		wr_addr = {~bank_q, w_q[IW-1:0]};
		wr_data = {ent_e, ent_s};
		case (state_q)
			ST_IDLE: begin
				rd_idx = (req == REQ_READ) ? {1'b0, in_idx} : '0;
				if (accept && (req == REQ_APPEND) && !full) begin
					wr_en   = 1'b1;
					wr_addr = {bank_q, cnt_q[IW-1:0]};
					wr_data = {in_end, in_start};
				end
			end
			ST_WALK: begin
				rd_idx = ptr_inc;
				case (act)
					ACT_DROP: begin
						wr_en = 1'b0;
					end
					ACT_SPLIT, ACT_TRIM_END: begin
						wr_en   = 1'b1;
						wr_data = {ms_m1_q, ent_s};
					end
					ACT_TRIM_START: begin
						wr_en   = 1'b1;
						wr_data = {ent_e, me_p1_q};
					end
					default: begin
						wr_en = 1'b1;
					end
				endcase
			end
			ST_SPLIT: begin
				wr_en   = 1'b1;
				wr_data = {spl_e_q, me_p1_q};
			end
			default: begin
				rd_idx = ptr_q;
			end
		endcase
	end

	assign rd_addr = {bank_q, rd_idx[IW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bank_q       <= 1'b0;
			cap_q        <= CAP_RESET;
			cnt_q        <= '0;
			orig_q       <= '0;
			ptr_q        <= '0;
			w_q          <= '0;
			stop_q       <= 1'b0;
			res_status_q <= STAT_OK;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (walk_end) begin
				bank_q <= ~bank_q;
			end
			if (accept) begin
				res_status_q <= STAT_OK;
				case (req)
					REQ_CLEAR: begin
						cnt_q <= '0;
					end
					REQ_APPEND: begin
						if (full) begin
							res_status_q <= STAT_NOSPACE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					REQ_EXCLUDE: begin
						orig_q <= cnt_q;
						ptr_q  <= '0;
						w_q    <= '0;
						stop_q <= 1'b0;
					end
					default: begin
						if (!idx_ok) begin
							res_status_q <= STAT_BADIDX;
						end
					end
				endcase
			end
			if (state_q == ST_WALK) begin
				ptr_q <= ptr_inc;
				case (act)
					ACT_DROP: begin
						cnt_q <= cnt_q - 1'b1;
					end
					ACT_SPLIT: begin
						cnt_q <= cnt_q + 1'b1;
						w_q   <= w_q + 1'b1;
					end
					ACT_NOSPACE: begin
						stop_q       <= 1'b1;
						res_status_q <= STAT_NOSPACE;
						w_q          <= w_q + 1'b1;
					end
					ACT_COPY_STOP: begin
						stop_q <= 1'b1;
						w_q    <= w_q + 1'b1;
					end
					default: begin
						w_q <= w_q + 1'b1;
					end
				endcase
			end
			if (state_q == ST_SPLIT) begin
				w_q <= w_q + 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ms_q        <= in_start;
			me_q        <= in_end;
			ms_m1_q     <= in_start - 1'b1;
			me_p1_q     <= in_end + 1'b1;
			res_start_q <= '0;
			res_end_q   <= '0;
		end
		if ((state_q == ST_WALK) && (act == ACT_SPLIT)) begin
			spl_e_q <= ent_e;
		end
		if (state_q == ST_RDWAIT) begin
			res_start_q <= ent_s;
			res_end_q   <= ent_e;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {res_end_q, res_start_q, cnt_q, res_status_q};
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} <= MAX_C)
		else $error("entry count above the list depth");

	a_walk_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (ptr_q < orig_q))
		else $error("walk pointer past the original count");

	a_walk_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (w_q < cnt_q))
		else $error("walk write pointer caught up with the running count");

	a_nospace: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && (res_status_q == STAT_NOSPACE)) |-> (cnt_q >= cap))
		else $error("no-space status while the list has room");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		walk_end |=> (bank_q != $past(bank_q)))
		else $error("bank did not swap at the end of a walk");
`endif

endmodule
